// ===== rtl/kti_pkg.sv =====
// shared types and constants for the keyframe track interpolator
package kti_pkg;

  localparam int MaxKeys   = 64;
  localparam int SlotW     = $clog2(MaxKeys);
  localparam int CountW    = 7;
  localparam int NumVals   = 10;
  localparam int ValIdxW   = 4;
  localparam int ValDepth  = MaxKeys * NumVals;
  localparam int ValAddrW  = $clog2(ValDepth);
  localparam int FracW     = 17;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam logic CFG_KEY_COUNT = 1'b0;
  localparam logic CFG_DURATION  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;        // latch input item
    logic write_key;     // write table word
    logic start;         // clear time, set running
    logic add_time;      // saturating add of time_step
    logic scan_rd;       // read key time at scan index
    logic scan_chk;      // compare read key time
    logic seg_rd0;       // read key0 of segment
    logic seg_rd1;       // read key1 of segment
    logic div_init;
    logic div_step;
    logic val_rd_a;      // read value a
    logic val_rd_b;      // read value b
    logic val_mul;       // multiply
    logic val_store;     // store interpolated value
    logic stop;          // ended
    logic load_out;
  } kti_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       running;
    logic       past_end;
    logic       scan_done;
    logic       div_done;
    logic       val_last;
  } kti_sts_t;

endpackage

// ===== rtl/keyframe_track_interpolator_core.sv =====
// top level of the keyframe track interpolator
// Usage: items enter on in_* (valid/stall). kind tick advances playback time
// by in_time_step and yields one item on out_* while running; kind write loads
// one keyframe word; kind start rewinds and begins playback.
// Configuration: cfg_index 0 is the key count, 1 the duration; write only
// while idle. cfg_ready is always high.
// A write or start passes through the decode state and back to idle; a tick
// that ends playback loads its result in the time state, registered to out_*;
// any other tick runs the linear segment scan through the key time memory,
// a 16-step serial divider and the read, multiply and store steps for each
// value through the single port of the value memory.
// One item at a time: in_stall stays high until the result has been taken.
// A stalled result holds on out_* until out_stall drops.
// Reset stops playback, clears time and frame; key tables stay unwritten,
// key count resets to 2 and duration to 0.
module keyframe_track_interpolator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_time_step,
  input  logic [5:0]  in_frame_slot,
  input  logic [3:0]  in_word_select,
  input  logic signed [31:0] in_word_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_play_time,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  output logic signed [31:0] out_color_r,
  output logic signed [31:0] out_color_g,
  output logic signed [31:0] out_color_b,
  output logic signed [31:0] out_color_a,
  output logic        out_ended,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import kti_pkg::*;

  logic [CountW-1:0] key_count_r;
  logic [31:0]       duration_r;
  kti_cmd_t cmd;
  kti_sts_t sts;
  logic [NumVals-1:0][31:0] vals;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= CountW'(2);
      duration_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_KEY_COUNT) key_count_r <= cfg_data[CountW-1:0];
      if (cfg_index == CFG_DURATION) duration_r <= cfg_data;
    end
  end

  kti_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

  kti_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_kind), .in_time_step(in_time_step), .in_frame_slot(in_frame_slot),
    .in_word_select(in_word_select), .in_word_value(in_word_value),
    .key_count(key_count_r), .duration(duration_r),
    .out_play_time(out_play_time), .out_vals(vals), .out_ended(out_ended));

  assign out_pos_x   = vals[0];
  assign out_pos_y   = vals[1];
  assign out_pos_z   = vals[2];
  assign out_rot_x   = vals[3];
  assign out_rot_y   = vals[4];
  assign out_rot_z   = vals[5];
  assign out_color_r = vals[6];
  assign out_color_g = vals[7];
  assign out_color_b = vals[8];
  assign out_color_a = vals[9];
endmodule

// ===== rtl/kti_ram.sv =====
// generic single-port ram with registered read
module kti_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/kti_datapath.sv =====
// keyframe tables, time, segment search, divider and interpolation
module kti_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kti_pkg::kti_cmd_t             cmd,
  output kti_pkg::kti_sts_t             sts,
  input  logic [1:0]                    in_kind,
  input  logic [31:0]                   in_time_step,
  input  logic [kti_pkg::SlotW-1:0]     in_frame_slot,
  input  logic [3:0]                    in_word_select,
  input  logic signed [31:0]            in_word_value,
  input  logic [kti_pkg::CountW-1:0]    key_count,
  input  logic [31:0]                   duration,
  output logic [31:0]                   out_play_time,
  output logic [kti_pkg::NumVals-1:0][31:0] out_vals,
  output logic                          out_ended
);
  import kti_pkg::*;

  logic [1:0]       kind_r;
  logic [31:0]      dt_r;
  logic [SlotW-1:0] slot_r;
  logic [3:0]       sel_r;
  logic [31:0]      wval_r;
  logic             running_r, running_nxt;
  logic [31:0]      time_r, time_nxt;
  logic [NumVals-1:0][31:0] frame_r;
  logic [SlotW:0]   scan_r;      // index of key tested
  logic [SlotW-1:0] seg_r;
  logic             found_r;
  logic [31:0]      k0_r;
  logic [ValIdxW-1:0] vidx_r;
  logic signed [31:0] va_r;
  logic signed [32:0] diff_r;
  logic signed [50:0] prod_r;
  logic [16:0]      q_r;
  logic [31:0]      rem_r;
  logic [31:0]      den_r;
  logic [4:0]       dcnt_r;
  logic             fzero_r;

  // key count clamped
  logic [SlotW:0] n_use;
  always_comb begin
    if (key_count < CountW'(2)) n_use = (SlotW+1)'(2);
    else if (key_count > CountW'(MaxKeys)) n_use = (SlotW+1)'(MaxKeys);
    else n_use = key_count[SlotW:0];
  end

  // key time memory
  logic             kt_we;
  logic [SlotW-1:0] kt_addr;
  logic [31:0]      kt_q;
  always_comb begin
    kt_we = cmd.write_key && sel_r == 4'd0;
    kt_addr = slot_r;
    if (cmd.scan_rd) kt_addr = scan_r[SlotW-1:0];
    else if (cmd.seg_rd0) kt_addr = seg_r;
    else if (cmd.seg_rd1) kt_addr = seg_r + SlotW'(1);
  end
  kti_ram #(.Width(32), .Depth(MaxKeys)) u_times (
    .clk(clk), .we(kt_we), .addr(kt_addr), .wdata(wval_r), .rdata(kt_q));

  // key value memory
  logic                kv_we;
  logic [ValAddrW-1:0] kv_addr;
  logic [31:0]         kv_q;
  logic [ValAddrW-1:0] seg_base;
  assign seg_base = ValAddrW'(seg_r) * ValAddrW'(NumVals);
  always_comb begin
    kv_we = cmd.write_key && sel_r != 4'd0 && sel_r <= 4'(NumVals);
    kv_addr = ValAddrW'(slot_r) * ValAddrW'(NumVals) + ValAddrW'(sel_r - 4'd1);
    if (cmd.val_rd_a) kv_addr = seg_base + ValAddrW'(vidx_r);
    else if (cmd.val_rd_b) kv_addr = seg_base + ValAddrW'(NumVals) + ValAddrW'(vidx_r);
  end
  kti_ram #(.Width(32), .Depth(ValDepth)) u_vals (
    .clk(clk), .we(kv_we), .addr(kv_addr), .wdata(wval_r), .rdata(kv_q));

  logic [32:0] sum;
  assign sum = {1'b0, time_r} + {1'b0, dt_r};
  logic [32:0] rem_sh;
  assign rem_sh = {rem_r, 1'b0};
  logic [31:0] num0, den0;
  assign num0 = time_r - k0_r;
  assign den0 = kt_q - k0_r;

  always_comb begin
    running_nxt = running_r;
    time_nxt = time_r;
    if (cmd.start) begin
      running_nxt = 1'b1;
      time_nxt = '0;
    end
    if (cmd.add_time) time_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (cmd.stop) running_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      time_r <= '0;
      frame_r <= '0;
      out_ended <= 1'b0;
    end else begin
      running_r <= running_nxt;
      time_r <= time_nxt;
      if (cmd.val_store) frame_r[vidx_r] <= va_r + prod_r[47:16];
      if (cmd.load_out) out_ended <= cmd.stop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      dt_r <= in_time_step;
      slot_r <= in_frame_slot;
      sel_r <= in_word_select;
      wval_r <= in_word_value;
      scan_r <= (SlotW+1)'(1);
      // last segment unless the scan finds a later key
      seg_r <= SlotW'(n_use - (SlotW+1)'(2));
      found_r <= 1'b0;
      vidx_r <= '0;
    end
    if (cmd.scan_chk && !found_r && time_r < kt_q) begin
      found_r <= 1'b1;
      seg_r <= SlotW'(scan_r - (SlotW+1)'(2));
    end
    if (cmd.scan_rd) scan_r <= scan_r + (SlotW+1)'(1);
    if (cmd.seg_rd1) k0_r <= kt_q;
    if (cmd.div_init) begin
      fzero_r <= (kt_q <= k0_r) || (time_r <= k0_r);
      den_r <= den0;
      rem_r <= num0;
      // fraction of one or more saturates without stepping
      if (num0 >= den0) begin
        q_r <= {1'b1, 16'd0};
        dcnt_r <= 5'd16;
      end else begin
        q_r <= '0;
        dcnt_r <= '0;
      end
    end
    if (cmd.div_step) begin
      // restoring divide, one fraction bit each step
      dcnt_r <= dcnt_r + 5'd1;
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= 32'(rem_sh - {1'b0, den_r});
        q_r <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        q_r <= {q_r[15:0], 1'b0};
      end
    end
    if (cmd.val_rd_b) va_r <= kv_q;
    if (cmd.val_mul) begin
      diff_r <= 33'(signed'(kv_q)) - 33'(va_r);
    end
    if (cmd.val_store) vidx_r <= vidx_r + ValIdxW'(1);
    if (cmd.load_out) out_play_time <= time_r;
  end

  logic [FracW-1:0] frac;
  always_comb begin
    frac = q_r;
    if (fzero_r) frac = '0;
  end

  // multiply with floor via arithmetic shift; diff*frac fits 50 bits
  logic signed [50:0] mul;
  assign mul = 51'(signed'(diff_r)) * 51'(signed'({1'b0, frac}));
  always_ff @(posedge clk) begin
    if (cmd.val_rd_a) prod_r <= '0;
    else if (cmd.val_mul) prod_r <= '0;
    else prod_r <= mul;
  end

  always_comb begin
    sts.kind = kind_r;
    sts.running = running_r;
    sts.past_end = time_r > duration;
    sts.scan_done = found_r || scan_r >= n_use;
    sts.div_done = dcnt_r == 5'd16;
    sts.val_last = vidx_r == ValIdxW'(NumVals - 1);
  end
  assign out_vals = frame_r;
endmodule

// ===== rtl/kti_ctrl.sv =====
// sequencing controller for the keyframe track interpolator
module kti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  kti_pkg::kti_sts_t sts,
  output kti_pkg::kti_cmd_t cmd
);
  import kti_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DEC   = 12'b000000000010,
    S_TIME  = 12'b000000000100,
    S_SCAN  = 12'b000000001000,
    S_SCHK  = 12'b000000010000,
    S_K0    = 12'b000000100000,
    S_K1    = 12'b000001000000,
    S_DIV   = 12'b000010000000,
    S_VA    = 12'b000100000000,
    S_VB    = 12'b001000000000,
    S_MUL   = 12'b010000000000,
    S_STORE = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   phase_r, phase_nxt;

  assign in_stall = state_r != S_IDLE || ovalid_r;
  assign out_valid = ovalid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ovalid_nxt = ovalid_r && out_stall;
    phase_nxt = phase_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_IDLE;
        case (sts.kind)
          KIND_WRITE: cmd.write_key = 1'b1;
          KIND_START: cmd.start = 1'b1;
          KIND_TICK: if (sts.running) begin
            cmd.add_time = 1'b1;
            state_nxt = S_TIME;
          end
          default: ;
        endcase
      end
      S_TIME: begin
        if (sts.past_end) begin
          cmd.stop = 1'b1;
          cmd.load_out = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_K0;
        else begin
          cmd.scan_rd = 1'b1;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        cmd.scan_chk = 1'b1;
        state_nxt = S_SCAN;
      end
      S_K0: begin
        cmd.seg_rd0 = 1'b1;
        state_nxt = S_K1;
      end
      S_K1: begin
        if (!phase_r) begin
          cmd.seg_rd1 = 1'b1;
          phase_nxt = 1'b1;
        end else begin
          cmd.div_init = 1'b1;
          phase_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_VA;
        else cmd.div_step = 1'b1;
      end
      S_VA: begin
        cmd.val_rd_a = 1'b1;
        state_nxt = S_VB;
      end
      S_VB: begin
        cmd.val_rd_b = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (!phase_r) begin
          cmd.val_mul = 1'b1;
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.val_store = 1'b1;
        if (sts.val_last) begin
          cmd.load_out = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_VA;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      phase_r <= phase_nxt;
    end
  end
endmodule

// ===== tb/tb_keyframe_track_interpolator_core.sv =====
// testbench for the keyframe track interpolator: directed and random playback checks
`timescale 1ns / 1ps

module tb_keyframe_track_interpolator_core;
  import kti_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int SettleCycles = 300;

  typedef struct packed {
    logic [31:0]              play_time;
    logic [NumVals-1:0][31:0] vals;
    logic                     ended;
  } frame_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = KIND_TICK;
  logic [31:0] in_time_step = '0;
  logic [5:0] in_frame_slot = '0;
  logic [3:0] in_word_select = '0;
  logic signed [31:0] in_word_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_play_time;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_rot_x, out_rot_y, out_rot_z;
  logic signed [31:0] out_color_r, out_color_g, out_color_b, out_color_a;
  logic out_ended;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_KEY_COUNT;
  logic [31:0] cfg_data = '0;

  keyframe_track_interpolator_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block
  logic [31:0] key_time_tab [MaxKeys];
  logic [31:0] key_val_tab [ValDepth];
  logic [6:0]  key_count_reg;
  logic [31:0] duration_reg;
  logic [31:0] play_clock;
  logic [31:0] frame_hold [NumVals];
  logic        playing;

  frame_item_t pending_frames[$];
  int fail_count = 0;
  int sent_items = 0;
  bit quiet = 1'b0;

  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    frame_item_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.play_time = out_play_time;
      got.vals = {out_color_a, out_color_b, out_color_g, out_color_r, out_rot_z, out_rot_y,
                  out_rot_x, out_pos_z, out_pos_y, out_pos_x};
      got.ended = out_ended;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result, actual time %h ended %b", $time, got.play_time,
                 got.ended);
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        if (got.play_time !== want.play_time) begin
          $display("%0t: play_time expected %h actual %h", $time, want.play_time,
                   got.play_time);
          fail_count++;
        end
        for (int i = 0; i < NumVals; i++) begin
          if (got.vals[i] !== want.vals[i]) begin
            $display("%0t: value %0d expected %h actual %h", $time, i, want.vals[i],
                     got.vals[i]);
            fail_count++;
          end
        end
        if (got.ended !== want.ended) begin
          $display("%0t: ended expected %b actual %b", $time, want.ended, got.ended);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [31:0] lerp_word(logic [31:0] a, logic [31:0] b,
                                            logic [16:0] frac);
    logic signed [63:0] sa, diff, prod;
    sa = {{32{a[31]}}, a};
    diff = {{32{b[31]}}, b} - sa;
    prod = diff * $signed({47'd0, frac});
    // arithmetic shift floors toward minus infinity
    return 32'(sa + (prod >>> 16));
  endfunction

  task automatic predict_item(logic [1:0] kind, logic [31:0] dt, logic [5:0] slot,
                              logic [3:0] sel, logic [31:0] val);
    logic [32:0] sum;
    int n, seg;
    logic [31:0] k0, k1;
    logic [63:0] quot;
    logic [16:0] frac;
    frame_item_t res;
    if (kind == KIND_WRITE) begin
      if (sel == 0) key_time_tab[slot] = val;
      else if (sel <= NumVals) key_val_tab[slot * NumVals + sel - 1] = val;
    end else if (kind == KIND_START) begin
      play_clock = '0;
      playing = 1'b1;
    end else if (kind == KIND_TICK && playing) begin
      sum = {1'b0, play_clock} + {1'b0, dt};
      play_clock = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      res.ended = 1'b0;
      if (play_clock > duration_reg) begin
        playing = 1'b0;
        res.ended = 1'b1;
      end else begin
        n = key_count_reg < 2 ? 2 : (key_count_reg > MaxKeys ? MaxKeys : key_count_reg);
        seg = n - 2;
        for (int i = 0; i + 1 < n; i++) begin
          if (play_clock < key_time_tab[i + 1]) begin
            seg = i;
            break;
          end
        end
        k0 = key_time_tab[seg];
        k1 = key_time_tab[seg + 1];
        if (k1 <= k0 || play_clock <= k0) begin
          frac = '0;
        end else begin
          quot = {16'd0, play_clock - k0, 16'd0} / {32'd0, k1 - k0};
          frac = quot > 64'd65536 ? 17'd65536 : quot[16:0];
        end
        for (int i = 0; i < NumVals; i++)
          frame_hold[i] = lerp_word(key_val_tab[seg * NumVals + i],
                                    key_val_tab[(seg + 1) * NumVals + i], frac);
      end
      res.play_time = play_clock;
      for (int i = 0; i < NumVals; i++) res.vals[i] = frame_hold[i];
      pending_frames.push_back(res);
    end
  endtask

  task automatic send_item(logic [1:0] kind, logic [31:0] dt, logic [5:0] slot,
                           logic [3:0] sel, logic [31:0] val);
    if (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_time_step <= dt;
    in_frame_slot <= slot;
    in_word_select <= sel;
    in_word_value <= val;
    do @(posedge clk); while (in_stall);
    predict_item(kind, dt, slot, sel, val);
    sent_items++;
  endtask

  task automatic send_tick(logic [31:0] dt);
    send_item(KIND_TICK, dt, 6'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic send_start();
    send_item(KIND_START, $urandom, 6'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic send_word(logic [5:0] slot, logic [3:0] sel, logic [31:0] val);
    send_item(KIND_WRITE, $urandom, slot, sel, val);
  endtask

  // hold the input, let every result arrive and the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_KEY_COUNT) key_count_reg = data[6:0];
    else duration_reg = data;
  endtask

  task automatic load_table(logic [31:0] span);
    for (int s = 0; s < MaxKeys; s++) begin
      send_word(6'(s), 4'd0, 32'(s) * span);
      for (int v = 1; v <= NumVals; v++) send_word(6'(s), 4'(v), $urandom);
    end
  endtask

  task automatic test_directed_edges();
    // idle before start: ticks and unused kinds give nothing
    send_tick($urandom);
    send_item(KindUnused, 32'hFFFF_FFFF, 6'h3F, 4'hF, 32'hFFFF_FFFF);
    send_word(6'd5, 4'd11, $urandom);
    send_word(6'd63, 4'd15, 32'h8000_0000);
    // value extremes across segment 0
    send_word(6'd0, 4'd1, 32'h8000_0000);
    send_word(6'd1, 4'd1, 32'h7FFF_FFFF);
    send_word(6'd0, 4'd2, 32'h7FFF_FFFF);
    send_word(6'd1, 4'd2, 32'h8000_0000);
    // zero duration: first tick at time zero plays, next one ends
    send_start();
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd7);
    write_reg(CFG_DURATION, 32'hFFFF_FFFF);
    write_reg(CFG_KEY_COUNT, 7'd64);
    send_start();
    send_tick(32'h0008_0000);
    send_start();
    send_tick(32'h0000_8001);
    // saturation and time beyond the last key
    send_tick(32'hFFFF_FFFF);
    send_tick(32'd5);
    drain_results();
    // zero-length segment and time before key0
    write_reg(CFG_KEY_COUNT, 7'd1);
    send_word(6'd0, 4'd0, 32'h0005_0000);
    send_word(6'd1, 4'd0, 32'h0005_0000);
    send_start();
    send_tick(32'h0001_0000);
    send_tick(32'h0008_0000);
    send_word(6'd0, 4'd0, 32'hFFFF_FFFF);
    send_tick(32'd0);
    send_word(6'd0, 4'd0, 32'd0);
  endtask

  task automatic test_random_playback();
    int phase, n, ticks, pick;
    logic [31:0] span, dur, dt_top;
    phase = 0;
    while (sent_items < 1800) begin
      quiet = (phase == 2);
      pick = $urandom_range(9);
      if (pick == 0) write_reg(CFG_KEY_COUNT, 7'd64);
      else if (pick == 1) write_reg(CFG_KEY_COUNT, 7'd2);
      else if (pick == 2) write_reg(CFG_KEY_COUNT, 7'($urandom_range(0, 1) ? 127 : 0));
      else write_reg(CFG_KEY_COUNT, 7'($urandom_range(2, 12)));
      n = key_count_reg < 2 ? 2 : (key_count_reg > MaxKeys ? MaxKeys : key_count_reg);
      span = $urandom_range(1, 1 << 20);
      for (int s = 0; s < n; s++)
        send_word(6'(s), 4'd0, $urandom_range(9) == 0 ? $urandom :
                  32'(s) * span + $urandom_range(0, span / 4));
      pick = $urandom_range(9);
      if (pick == 0) dur = 32'hFFFF_FFFF;
      else if (pick == 1) dur = 32'd0;
      else dur = 32'(n - 1) * span + $urandom_range(0, span);
      write_reg(CFG_DURATION, dur);
      repeat ($urandom_range(1, 4)) begin
        send_start();
        ticks = $urandom_range(4, 30);
        dt_top = (dur == 32'hFFFF_FFFF) ? 32'(n) * span / ticks : dur / ticks * 2 + 1;
        for (int i = 0; i < ticks; i++) begin
          pick = $urandom_range(99);
          if (pick < 6) send_word(6'($urandom_range(0, n - 1)), 4'($urandom_range(1, 10)),
                                  $urandom);
          else if (pick < 8) send_item(KindUnused, $urandom, 6'($urandom), 4'($urandom),
                                       $urandom);
          else if (pick < 10) send_start();
          else if (pick < 12) send_word(6'($urandom), 4'($urandom_range(11, 15)), $urandom);
          else if (pick < 15) send_tick($urandom);
          else send_tick($urandom_range(0, dt_top));
        end
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    key_count_reg = 7'd2;
    duration_reg = '0;
    play_clock = '0;
    playing = 1'b0;
    for (int i = 0; i < NumVals; i++) frame_hold[i] = '0;
    load_table(32'h0001_0000);
    test_directed_edges();
    test_random_playback();
    drain_results();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kti_pkg.sv
rtl/kti_ram.sv
rtl/kti_datapath.sv
rtl/kti_ctrl.sv
rtl/keyframe_track_interpolator_core.sv
tb/tb_keyframe_track_interpolator_core.sv
